@@ rtl/mvfb_pkg.sv @@
// ----------------------------------------------------------------------------
// mvfb_pkg
// Shared types, constants and the crc byte update for the mavlink v1 framer.
// ----------------------------------------------------------------------------
package mvfb_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [7:0]  FrameStart = 8'hFE;
  localparam logic [15:0] CrcSeed    = 16'hFFFF;
  localparam logic [7:0]  SysIdRst   = 8'hFF;
  localparam logic [7:0]  CompIdRst  = 8'h01;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SYS_ID       = 2'd0,
    REG_COMPONENT_ID = 2'd1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] sys_id;
    logic [7:0] component_id;
  } cfg_t;

  // one accepted payload word plus what its frame needs
  typedef struct packed {
    logic       first;
    logic       last;
    logic [7:0] payload;
    logic [7:0] length;
    logic [7:0] msg_id;
    logic [7:0] seq;
    logic [7:0] extra;
  } item_t;

  // x.25 / mcrf4xx update, one byte
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'h0};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b0, t, 3'b0} ^ {12'h000, t[7:4]};
  endfunction

endpackage

@@ rtl/mvfb_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// mvfb_cfg_regs
// System and component id registers behind the configuration write channel.
// ----------------------------------------------------------------------------
module mvfb_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mvfb_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                  cfg_data_i,
  output mvfb_pkg::cfg_t              cfg_o
);

  mvfb_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        mvfb_pkg::REG_SYS_ID:       cfg_d.sys_id       = cfg_data_i;
        mvfb_pkg::REG_COMPONENT_ID: cfg_d.component_id = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sys_id       <= mvfb_pkg::SysIdRst;
      cfg_q.component_id <= mvfb_pkg::CompIdRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/mvfb_ingress.sv @@
// ----------------------------------------------------------------------------
// mvfb_ingress
// Input register and frame bookkeeping: byte count, sequence number, latches.
// ----------------------------------------------------------------------------
module mvfb_ingress (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    payload_byte_i,
  input  logic [7:0]    payload_length_i,
  input  logic [7:0]    message_id_i,
  input  logic [7:0]    crc_extra_i,
  input  logic          done_i,
  output logic          item_valid_o,
  output mvfb_pkg::item_t item_o
);

  logic            item_valid_q, item_valid_d;
  mvfb_pkg::item_t item_q, item_d;
  logic [7:0]      left_q, left_d;
  logic [7:0]      seq_q, seq_d;
  logic            accept, first, drop;
  logic [7:0]      eff_len;

  assign in_stall_o = item_valid_q && !done_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign first      = (left_q == 8'd0);
  // zero length on a frame's first word: dropped, nothing changes
  assign drop       = first && (payload_length_i == 8'd0);
  assign eff_len    = first ? payload_length_i : left_q;

  always_comb begin
    item_valid_d = item_valid_q && !done_i;
    item_d       = item_q;
    left_d       = left_q;
    seq_d        = seq_q;
    if (accept && !drop) begin
      item_valid_d   = 1'b1;
      item_d.first   = first;
      item_d.last    = (eff_len == 8'd1);
      item_d.payload = payload_byte_i;
      left_d         = eff_len - 8'd1;
      if (first) begin
        item_d.length = payload_length_i;
        item_d.msg_id = message_id_i;
        item_d.extra  = crc_extra_i;
        item_d.seq    = seq_q;
        seq_d         = seq_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      left_q       <= 8'd0;
      seq_q        <= 8'd0;
    end else begin
      item_valid_q <= item_valid_d;
      left_q       <= left_d;
      seq_q        <= seq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = item_valid_q;
  assign item_o       = item_q;

`ifndef SYNTHESIS
  a_item_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_q && !done_i |=> item_valid_q && $stable(item_q))
    else $error("held item changed before it was sent");
  a_last_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_q && item_q.last |-> left_q == 8'd0)
    else $error("last word of frame but bytes remain");
  a_mid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_q && !item_q.last |-> left_q != 8'd0)
    else $error("frame word not last but count is zero");
`endif

endmodule

@@ rtl/mvfb_emitter.sv @@
// ----------------------------------------------------------------------------
// mvfb_emitter
// Byte sequencer: header, payload and crc bytes into the output register.
// ----------------------------------------------------------------------------
module mvfb_emitter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  mvfb_pkg::item_t item_i,
  input  mvfb_pkg::cfg_t  cfg_i,
  output logic            done_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      frame_byte_o,
  output logic            end_of_frame_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_LEN, S_SEQ, S_SYS, S_COMP, S_MID, S_PAY, S_CRCL, S_CRCH
  } step_e;

  step_e       step_q, step_d, cur;
  logic [15:0] crc_q, crc_d, crc_fin;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  byte_q, byte_d, cur_byte;
  logic        eof_q, eof_d;
  logic        adv;

  // idle sequencer starts a new item without a bubble
  assign cur = (step_q == S_IDLE) ? (item_i.first ? S_START : S_PAY) : step_q;
  assign adv = item_valid_i && (!out_valid_q || !out_stall_i);
  assign crc_fin = mvfb_pkg::crc_feed(crc_q, item_i.extra);

  always_comb begin
    case (cur)
      S_START: cur_byte = mvfb_pkg::FrameStart;
      S_LEN:   cur_byte = item_i.length;
      S_SEQ:   cur_byte = item_i.seq;
      S_SYS:   cur_byte = cfg_i.sys_id;
      S_COMP:  cur_byte = cfg_i.component_id;
      S_MID:   cur_byte = item_i.msg_id;
      S_PAY:   cur_byte = item_i.payload;
      S_CRCL:  cur_byte = crc_fin[7:0];
      S_CRCH:  cur_byte = crc_q[15:8];
      default: cur_byte = 8'h00;
    endcase
  end

  always_comb begin
    step_d      = step_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q && out_stall_i;
    byte_d      = byte_q;
    eof_d       = eof_q;
    done_o      = 1'b0;
    if (adv) begin
      out_valid_d = 1'b1;
      byte_d      = cur_byte;
      eof_d       = (cur == S_CRCH);
      case (cur)
        S_START: begin
          crc_d  = mvfb_pkg::CrcSeed;
          step_d = S_LEN;
        end
        S_LEN: begin
          crc_d  = mvfb_pkg::crc_feed(crc_q, cur_byte);
          step_d = S_SEQ;
        end
        S_SEQ: begin
          crc_d  = mvfb_pkg::crc_feed(crc_q, cur_byte);
          step_d = S_SYS;
        end
        S_SYS: begin
          crc_d  = mvfb_pkg::crc_feed(crc_q, cur_byte);
          step_d = S_COMP;
        end
        S_COMP: begin
          crc_d  = mvfb_pkg::crc_feed(crc_q, cur_byte);
          step_d = S_MID;
        end
        S_MID: begin
          crc_d  = mvfb_pkg::crc_feed(crc_q, cur_byte);
          step_d = S_PAY;
        end
        S_PAY: begin
          crc_d = mvfb_pkg::crc_feed(crc_q, cur_byte);
          if (item_i.last) begin
            step_d = S_CRCL;
          end else begin
            step_d = S_IDLE;
            done_o = 1'b1;
          end
        end
        S_CRCL: begin
          crc_d  = crc_fin;
          step_d = S_CRCH;
        end
        S_CRCH: begin
          step_d = S_IDLE;
          done_o = 1'b1;
        end
        default: step_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= S_IDLE;
      crc_q       <= mvfb_pkg::CrcSeed;
      out_valid_q <= 1'b0;
      byte_q      <= 8'h00;
      eof_q       <= 1'b0;
    end else begin
      step_q      <= step_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
      byte_q      <= byte_d;
      eof_q       <= eof_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_byte_o   = byte_q;
  assign end_of_frame_o = eof_q;

`ifndef SYNTHESIS
  a_busy_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != S_IDLE |-> item_valid_i)
    else $error("sequencer mid-item with no item held");
  a_start_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && cur == S_START |=> out_valid_q && byte_q == mvfb_pkg::FrameStart)
    else $error("frame did not open with start byte");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> step_q == S_IDLE)
    else $error("sequencer not idle after finishing an item");
`endif

endmodule

@@ rtl/mavlink_v1_frame_builder_top.sv @@
// ----------------------------------------------------------------------------
// mavlink_v1_frame_builder_top
// MAVLink v1 framer: header, payload and x.25 crc from a payload word stream.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   in      | sink      | in_valid_i / in_stall_o | payload byte, length, id, extra
//   out     | source    | out_valid_o/out_stall_i | frame byte, end of frame
//   cfg     | sink      | cfg_valid_i/cfg_ready_o | register index, data
//
// one frame byte leaves per cycle while the output is not stalled; a middle payload
// word yields 1 frame byte, a frame's first word 7 bytes and its last word 3 (9 when both).
// the pace is set by the single output register, which holds one byte at a time.
// reset: sequence number 0, no frame open, system id 255, component id 1.
// output stall holds the output register and, through it, the input side.
// ----------------------------------------------------------------------------
module mavlink_v1_frame_builder_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   payload_byte_i,
  input  logic [7:0]                   payload_length_i,
  input  logic [7:0]                   message_id_i,
  input  logic [7:0]                   crc_extra_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   frame_byte_o,
  output logic                         end_of_frame_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mvfb_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                   cfg_data_i
);

  mvfb_pkg::cfg_t  cfg;
  mvfb_pkg::item_t item;
  logic            item_valid;
  logic            done;

  mvfb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mvfb_ingress u_ingress (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .payload_byte_i   (payload_byte_i),
    .payload_length_i (payload_length_i),
    .message_id_i     (message_id_i),
    .crc_extra_i      (crc_extra_i),
    .done_i           (done),
    .item_valid_o     (item_valid),
    .item_o           (item)
  );

  mvfb_emitter u_emitter (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_valid),
    .item_i         (item),
    .cfg_i          (cfg),
    .done_o         (done),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_byte_o   (frame_byte_o),
    .end_of_frame_o (end_of_frame_o)
  );

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mavlink v1 framer. A directed table and then
// random frames are driven through the word channel under changing idle
// mixes. Every frame byte is checked against a predictor that rebuilds the
// header, the payload and the x.25 crc, with its own sequence and id copies.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 12;
  localparam int unsigned PhaseWords    = 38;
  localparam logic [15:0] X25PolyRev    = 16'h8408;

  // indexes beyond the register file, writes to them must be dropped
  localparam logic [mvfb_pkg::CfgIdxW-1:0] RegSpareA = 2'd2;
  localparam logic [mvfb_pkg::CfgIdxW-1:0] RegSpareB = 2'd3;

  localparam int TxIdlePct [4] = '{0, 53, 0, 8};
  localparam int RxIdlePct [4] = '{0, 0, 53, 8};

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e                     kind;
    logic [mvfb_pkg::CfgIdxW-1:0]  idx;
    logic [7:0]                    pb;
    logic [7:0]                    len;
    logic [7:0]                    mid;
    logic [7:0]                    extra;
    logic                          chk;
    logic [7:0]                    seq;
    logic [7:0]                    sys;
    logic [7:0]                    comp;
  } step_row_t;

  typedef struct packed {
    logic [7:0] fbyte;
    logic       eof;
  } frame_out_t;

  // register rows carry their data in pb; chk rows carry a typed header
  localparam int DirRows = 21;
  step_row_t dir_table [DirRows] = '{
    '{ROW_WORD, '0, 8'h00, 8'h01, 8'h00, 8'h00, 1'b1, 8'h00, 8'hFF, 8'h01},
    '{ROW_WORD, '0, 8'hFF, 8'h01, 8'hFF, 8'hFF, 1'b1, 8'h01, 8'hFF, 8'h01},
    '{ROW_WORD, '0, 8'hAA, 8'h00, 8'h12, 8'h34, 1'b0, '0, '0, '0},
    '{ROW_WORD, '0, 8'h11, 8'h03, 8'h4C, 8'h1F, 1'b1, 8'h02, 8'hFF, 8'h01},
    '{ROW_WORD, '0, 8'h22, 8'h00, 8'hFF, 8'hFF, 1'b0, '0, '0, '0},
    '{ROW_WORD, '0, 8'h33, 8'hFF, 8'h00, 8'h00, 1'b0, '0, '0, '0},
    '{ROW_REG, mvfb_pkg::REG_SYS_ID, 8'h00, '0, '0, '0, 1'b0, '0, '0, '0},
    '{ROW_REG, mvfb_pkg::REG_COMPONENT_ID, 8'h00, '0, '0, '0, 1'b0, '0, '0, '0},
    '{ROW_REG, RegSpareA, 8'h3C, '0, '0, '0, 1'b0, '0, '0, '0},
    '{ROW_REG, RegSpareB, 8'hC3, '0, '0, '0, 1'b0, '0, '0, '0},
    '{ROW_WORD, '0, 8'h5A, 8'h02, 8'h80, 8'h7E, 1'b1, 8'h03, 8'h00, 8'h00},
    '{ROW_WORD, '0, 8'hA5, 8'h01, 8'h01, 8'h01, 1'b0, '0, '0, '0},
    '{ROW_WORD, '0, 8'hC3, 8'h00, 8'hFF, 8'h00, 1'b0, '0, '0, '0},
    '{ROW_REG, mvfb_pkg::REG_SYS_ID, 8'hFF, '0, '0, '0, 1'b0, '0, '0, '0},
    '{ROW_REG, mvfb_pkg::REG_COMPONENT_ID, 8'hFF, '0, '0, '0, 1'b0, '0, '0, '0},
    '{ROW_WORD, '0, 8'h0F, 8'h01, 8'hF0, 8'h55, 1'b1, 8'h04, 8'hFF, 8'hFF},
    '{ROW_WORD, '0, 8'h96, 8'h02, 8'h3B, 8'h9C, 1'b1, 8'h05, 8'hFF, 8'hFF},
    '{ROW_WORD, '0, 8'h69, 8'h80, 8'hC4, 8'h63, 1'b0, '0, '0, '0},
    '{ROW_REG, mvfb_pkg::REG_SYS_ID, 8'h2A, '0, '0, '0, 1'b0, '0, '0, '0},
    '{ROW_REG, mvfb_pkg::REG_COMPONENT_ID, 8'h07, '0, '0, '0, 1'b0, '0, '0, '0},
    '{ROW_WORD, '0, 8'h3C, 8'h01, 8'h07, 8'hE1, 1'b1, 8'h06, 8'h2A, 8'h07}
  };

  logic                          clk_i            = 1'b0;
  logic                          rst_ni           = 1'b0;
  logic                          in_valid_i       = 1'b0;
  logic                          in_stall_o;
  logic [7:0]                    payload_byte_i   = '0;
  logic [7:0]                    payload_length_i = '0;
  logic [7:0]                    message_id_i     = '0;
  logic [7:0]                    crc_extra_i      = '0;
  logic                          out_valid_o;
  logic                          out_stall_i      = 1'b0;
  logic [7:0]                    frame_byte_o;
  logic                          end_of_frame_o;
  logic                          cfg_valid_i      = 1'b0;
  logic                          cfg_ready_o;
  logic [mvfb_pkg::CfgIdxW-1:0]  cfg_index_i      = '0;
  logic [7:0]                    cfg_data_i       = '0;

  // typed header travelling with the word being offered
  logic                row_chk  = 1'b0;
  logic [7:0]          row_seq  = '0;
  logic [7:0]          row_sys  = '0;
  logic [7:0]          row_comp = '0;

  // framer state as predicted
  logic [7:0]          seq_nr     = '0;
  logic [15:0]         crc_acc    = mvfb_pkg::CrcSeed;
  logic [7:0]          words_left = '0;
  logic [7:0]          extra_lat  = '0;
  logic [7:0]          sys_reg    = mvfb_pkg::SysIdRst;
  logic [7:0]          comp_reg   = mvfb_pkg::CompIdRst;

  frame_out_t          frame_q [$];

  int                  tx_pct = 0;
  int                  rx_pct = 0;
  int unsigned         mismatches    = 0;
  int unsigned         frames_seen   = 0;
  int unsigned         words_taken   = 0;
  int unsigned         bytes_checked = 0;
  int unsigned         reg_writes    = 0;
  int unsigned         idle_cycles   = 0;
  int unsigned         sent_words    = 0;

  mavlink_v1_frame_builder_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .payload_byte_i   (payload_byte_i),
    .payload_length_i (payload_length_i),
    .message_id_i     (message_id_i),
    .crc_extra_i      (crc_extra_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .frame_byte_o     (frame_byte_o),
    .end_of_frame_o   (end_of_frame_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // bit-serial reflected form of the x.25 crc
  function automatic logic [15:0] x25_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ X25PolyRev) : (c >> 1);
    end
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic predict_frame_bytes(input logic [7:0] pb, input logic [7:0] len,
                                     input logic [7:0] mid, input logic [7:0] extra);
    logic [7:0] hdr [5];
    logic [7:0] shown [5];
    if (words_left == 0) begin
      // zero length opens nothing and uses no sequence number
      if (len == 0) return;
      hdr = '{len, seq_nr, sys_reg, comp_reg, mid};
      shown = hdr;
      if (row_chk) begin
        shown[1] = row_seq;
        shown[2] = row_sys;
        shown[3] = row_comp;
      end
      crc_acc = mvfb_pkg::CrcSeed;
      frame_q.push_back(frame_out_t'{mvfb_pkg::FrameStart, 1'b0});
      for (int i = 0; i < 5; i++) begin
        crc_acc = x25_update(crc_acc, hdr[i]);
        frame_q.push_back(frame_out_t'{shown[i], 1'b0});
      end
      seq_nr     = seq_nr + 8'd1;
      extra_lat  = extra;
      words_left = len;
      frames_seen++;
    end
    crc_acc = x25_update(crc_acc, pb);
    frame_q.push_back(frame_out_t'{pb, 1'b0});
    words_left = words_left - 8'd1;
    words_taken++;
    if (words_left == 0) begin
      crc_acc = x25_update(crc_acc, extra_lat);
      frame_q.push_back(frame_out_t'{crc_acc[7:0], 1'b0});
      frame_q.push_back(frame_out_t'{crc_acc[15:8], 1'b1});
    end
  endtask

  // prediction, checking, receiver stall and watchdog, all on the same edge
  always @(posedge clk_i) begin
    frame_out_t exp_out;
    logic       progress;
    if (rst_ni) begin
      progress = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        predict_frame_bytes(payload_byte_i, payload_length_i, message_id_i, crc_extra_i);
        progress = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        progress = 1'b1;
        if (frame_q.size() == 0) begin
          report_mismatch($sformatf("unexpected frame byte %02h eof %0b",
                                    frame_byte_o, end_of_frame_o));
        end else begin
          exp_out = frame_q.pop_front();
          if (frame_byte_o !== exp_out.fbyte) begin
            report_mismatch($sformatf("frame byte %02h, want %02h",
                                      frame_byte_o, exp_out.fbyte));
          end
          if (end_of_frame_o !== exp_out.eof) begin
            report_mismatch($sformatf("end of frame %0b, want %0b on byte %02h",
                                      end_of_frame_o, exp_out.eof, exp_out.fbyte));
          end
          bytes_checked++;
        end
      end
      if (cfg_valid_i && cfg_ready_o) progress = 1'b1;
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("[%0t] watchdog: no handshake for %0d cycles", $time, idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
    out_stall_i <= ($urandom_range(99) < rx_pct);
  end

  task automatic send_word(input logic [7:0] pb, input logic [7:0] len,
                           input logic [7:0] mid, input logic [7:0] extra,
                           input logic chk, input logic [7:0] kseq,
                           input logic [7:0] ksys, input logic [7:0] kcomp);
    while ($urandom_range(99) < tx_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    payload_byte_i   <= pb;
    payload_length_i <= len;
    message_id_i     <= mid;
    crc_extra_i      <= extra;
    row_chk          <= chk;
    row_seq          <= kseq;
    row_sys          <= ksys;
    row_comp         <= kcomp;
    do @(posedge clk_i); while (in_stall_o);
    sent_words++;
  endtask

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  // first word carries the header fields, later ones carry ignored noise
  task automatic send_frame(input logic [7:0] len);
    send_word(rand_byte(), len, rand_byte(), rand_byte(), 1'b0, '0, '0, '0);
    for (int i = 1; i < len; i++) begin
      send_word(rand_byte(), rand_byte(), rand_byte(), rand_byte(), 1'b0, '0, '0, '0);
    end
  endtask

  function automatic logic [7:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 8'($urandom_range(4, 1));
    if (r < 95) return 8'($urandom_range(16, 5));
    return 8'($urandom_range(64, 17));
  endfunction

  // a dropped zero-length word may still be in flight when the queue empties
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (frame_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [mvfb_pkg::CfgIdxW-1:0] idx,
                           input logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      mvfb_pkg::REG_SYS_ID:       sys_reg  = data;
      mvfb_pkg::REG_COMPONENT_ID: comp_reg = data;
      default: ;
    endcase
    reg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    step_row_t  row;
    logic       words_open;
    int unsigned start_words;
    words_open = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirRows; i++) begin
      row = dir_table[i];
      if (row.kind == ROW_REG) begin
        if (words_open) drain();
        words_open = 1'b0;
        write_reg(row.idx, row.pb);
      end else begin
        send_word(row.pb, row.len, row.mid, row.extra, row.chk, row.seq, row.sys, row.comp);
        words_open = 1'b1;
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      tx_pct = TxIdlePct[ph];
      rx_pct = RxIdlePct[ph];
      case (ph)
        0: begin
          write_reg(mvfb_pkg::REG_SYS_ID, 8'h00);
          write_reg(mvfb_pkg::REG_COMPONENT_ID, 8'hFF);
        end
        1: begin
          write_reg(mvfb_pkg::REG_SYS_ID, 8'hFF);
          write_reg(mvfb_pkg::REG_COMPONENT_ID, 8'h00);
        end
        default: begin
          write_reg(mvfb_pkg::REG_SYS_ID, rand_byte());
          write_reg(mvfb_pkg::REG_COMPONENT_ID, rand_byte());
        end
      endcase
      write_reg(($urandom_range(1) != 0) ? RegSpareA : RegSpareB, rand_byte());
      start_words = sent_words;
      while (sent_words - start_words < PhaseWords) begin
        if ($urandom_range(9) == 0) begin
          send_word(rand_byte(), 8'h00, rand_byte(), rand_byte(), 1'b0, '0, '0, '0);
        end
        send_frame(pick_len());
      end
    end

    drain();
    $display("covered %0d frames, %0d payload words, %0d frame bytes, %0d register writes",
             frames_seen, words_taken, bytes_checked, reg_writes);
    $display("idle mixes: none, sender, receiver, both; zero-length and spare index drops");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule
